FILE: rtl/core/msttt_pkg.sv
// Shared types and codes for the multi-slot timer table.
// Used by msttt_cell, msttt_seq and multi_slot_timer_table_top.
package msttt_pkg;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_START_ONE = 3'd1;
  localparam logic [2:0] CMD_START_PER = 3'd2;
  localparam logic [2:0] CMD_STOP      = 3'd3;
  localparam logic [2:0] CMD_RESTART   = 3'd4;
  localparam logic [2:0] CMD_RESET_ALL = 3'd5;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // expiries reported per tick
  localparam int MAX_RESULTS = 16;
  localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [7:0]  owner;
    logic [31:0] period;
    logic [31:0] count;
    logic        periodic;
  } slot_t;

  typedef struct packed {
    logic shift;  // rotate the ring one place toward the head
    logic clr;    // empty every slot
  } ring_ctl_t;

endpackage

FILE: rtl/core/msttt_cell.sv
// One timer slot of the ring: holds a slot record, passes it on when the
// ring rotates. Depends on msttt_pkg.
module msttt_cell (
  input  logic               clk,
  input  logic               rst,
  input  msttt_pkg::ring_ctl_t ctl,
  input  msttt_pkg::slot_t   d,
  output msttt_pkg::slot_t   q
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= d;
    end
  end

endmodule

FILE: rtl/core/msttt_seq.sv
// Command sequencer: walks the slot ring, updates the slot at the head,
// and drives the result ports. Depends on msttt_pkg.
module msttt_seq #(
  parameter int SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0]           command,
  input  logic [7:0]           handle,
  input  logic [31:0]          period_ticks,
  output logic                 busy,
  input  msttt_pkg::slot_t     head,
  output msttt_pkg::slot_t     head_new,
  output msttt_pkg::ring_ctl_t ctl,
  output logic                 strobe,
  output logic                 kind,
  output logic                 ok,
  output logic [3:0]           slot,
  output logic [7:0]           owner,
  output logic                 last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                          state;
  logic [2:0]                      cmd_r;
  logic [7:0]                      h_r;
  logic [31:0]                     per_r;
  logic [IDX_W-1:0]                idx;
  logic                            found;
  logic [IDX_W-1:0]                found_idx;
  logic                            pend_valid;
  logic [IDX_W-1:0]                pend_idx;
  logic [7:0]                      pend_owner;
  logic [msttt_pkg::FIRE_W-1:0]    fire_cnt;

  logic        hit;
  logic        fire;
  logic [31:0] cnt_dec;
  logic        accept;

  function automatic logic [3:0] slot_lo(input logic [IDX_W-1:0] x);
    logic [IDX_W+3:0] w;
    w = {4'b0, x};
    return w[3:0];
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    ctl.shift = (state == S_WALK);
    ctl.clr   = accept && (command == msttt_pkg::CMD_RESET_ALL);
  end

  // head slot update
  always_comb begin
    head_new = head;
    hit      = 1'b0;
    fire     = 1'b0;
    cnt_dec  = head.count - 32'd1;
    case (cmd_r)
      msttt_pkg::CMD_TICK: begin
        if (head.count != 32'd0) begin
          if (cnt_dec == 32'd0) begin
            fire           = 1'b1;
            head_new.count = head.periodic ? head.period : 32'd0;
          end else begin
            head_new.count = cnt_dec;
          end
        end
      end
      msttt_pkg::CMD_START_ONE, msttt_pkg::CMD_START_PER: begin
        if (!found && h_r != 8'd0 && head.owner == 8'd0) begin
          hit               = 1'b1;
          head_new.owner    = h_r;
          head_new.period   = per_r;
          head_new.count    = per_r;
          head_new.periodic = (cmd_r == msttt_pkg::CMD_START_PER);
        end
      end
      msttt_pkg::CMD_STOP: begin
        if (!found && h_r != 8'd0 && head.owner == h_r) begin
          hit      = 1'b1;
          head_new = '0;
        end
      end
      msttt_pkg::CMD_RESTART: begin
        if (!found && h_r != 8'd0 && head.owner == h_r) begin
          hit            = 1'b1;
          head_new.count = head.period;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      strobe     <= 1'b0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      fire_cnt   <= '0;
      idx        <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r      <= command;
            h_r        <= handle;
            per_r      <= period_ticks;
            idx        <= '0;
            found      <= 1'b0;
            pend_valid <= 1'b0;
            fire_cnt   <= '0;
            if (command <= msttt_pkg::CMD_RESTART) begin
              state <= S_WALK;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WALK: begin
          if (hit) begin
            found     <= 1'b1;
            found_idx <= idx;
          end
          // hold one expiry back so the final one can carry last
          if (fire && fire_cnt < msttt_pkg::FIRE_W'(msttt_pkg::MAX_RESULTS)) begin
            if (pend_valid) begin
              strobe <= 1'b1;
              kind   <= msttt_pkg::KIND_EXPIRY;
              ok     <= 1'b1;
              slot   <= slot_lo(pend_idx);
              owner  <= pend_owner;
              last   <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_idx   <= idx;
            pend_owner <= head.owner;
            fire_cnt   <= fire_cnt + 1'b1;
          end
          idx <= idx + 1'b1;
          if (idx == IDX_W'(SLOTS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
          last  <= 1'b1;
          if (cmd_r == msttt_pkg::CMD_TICK) begin
            strobe <= pend_valid;
            kind   <= msttt_pkg::KIND_EXPIRY;
            ok     <= 1'b1;
            slot   <= slot_lo(pend_idx);
            owner  <= pend_owner;
          end else if (cmd_r == msttt_pkg::CMD_RESET_ALL) begin
            strobe <= 1'b1;
            kind   <= msttt_pkg::KIND_ACK;
            ok     <= 1'b1;
            slot   <= 4'd0;
            owner  <= 8'd0;
          end else begin
            strobe <= 1'b1;
            kind   <= msttt_pkg::KIND_ACK;
            ok     <= found;
            slot   <= found ? slot_lo(found_idx) : 4'd0;
            owner  <= found ? h_r : 8'd0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/multi_slot_timer_table_top.sv
// Multi-slot timer table, top level. Depends on msttt_pkg, msttt_cell, msttt_seq.
//
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high and
//   busy low; command, handle and period_ticks are sampled there.
//   Result channel: each result sits on kind/ok/slot/owner/last for one cycle
//   with strobe high. The receiver cannot stall; results are never held.
// Timing:
//   The slots live in a ring of SLOTS cells that rotates one place per cycle
//   during a walk, past a single update unit at its head. Tick, start, stop
//   and restart walk the whole ring and then pass a closing state, with busy
//   high throughout; no new command is taken until busy is low again.
//   Reset-all and unknown commands skip the walk and go to the closing state.
//   Expiry results come out during the walk in slot order, the last one
//   (last=1) in the first cycle with busy low again; a command acknowledge
//   appears in that same cycle. A tick with no expiry gives no result.
// Reset:
//   rst (synchronous, active high) empties every slot at once and returns
//   the block to idle; reset-all does the same to the slots when it is taken.
module multi_slot_timer_table_top #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [7:0]  handle,
  input  logic [31:0] period_ticks,
  output logic        strobe,
  output logic        kind,
  output logic        ok,
  output logic [3:0]  slot,
  output logic [7:0]  owner,
  output logic        last
);

  msttt_pkg::slot_t     ring_q [SLOTS];
  msttt_pkg::slot_t     head_new;
  msttt_pkg::ring_ctl_t ctl;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      msttt_cell u_cell (
        .clk (clk),
        .rst (rst),
        .ctl (ctl),
        .d   (head_new),
        .q   (ring_q[i])
      );
    end else begin : g_mid
      msttt_cell u_cell (
        .clk (clk),
        .rst (rst),
        .ctl (ctl),
        .d   (ring_q[i+1]),
        .q   (ring_q[i])
      );
    end
  end

  msttt_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .handle       (handle),
    .period_ticks (period_ticks),
    .busy         (busy),
    .head         (ring_q[0]),
    .head_new     (head_new),
    .ctl          (ctl),
    .strobe       (strobe),
    .kind         (kind),
    .ok           (ok),
    .slot         (slot),
    .owner        (owner),
    .last         (last)
  );

`ifndef SYNTHESIS
  a_no_shift_on_clear: assert property (@(posedge clk) disable iff (rst)
    !(ctl.shift && ctl.clr))
    else $error("ring cleared while rotating");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_ack_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == msttt_pkg::KIND_ACK) |-> last)
    else $error("acknowledge without last");

  a_clear_only_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.clr |-> !busy)
    else $error("ring cleared during a walk");
`endif

endmodule
